[src/rrhs_pkg.sv]
// Shared types, constants and codes for the ring replica host selector.
package rrhs_pkg;

	// Default sizes and fixed field widths
	localparam int NODES_DEF    = 1024;
	localparam int MAX_REPL_DEF = 16;
	localparam int KEY_W        = 32;
	localparam int NODE_W       = 10;
	localparam int HOST_W       = 10;
	localparam int CFG_N_W      = 11;
	localparam int CFG_K_W      = 5;
	localparam int APB_AW       = 3;
	localparam int APB_DW       = 32;

	localparam logic [CFG_N_W-1:0] CFG_N_RST = 11'd1024;
	localparam logic [CFG_K_W-1:0] CFG_K_RST = 5'd3;

	// Operation codes
	localparam logic [1:0] OP_UP     = 2'd0;
	localparam logic [1:0] OP_DOWN   = 2'd1;
	localparam logic [1:0] OP_LOOKUP = 2'd2;
	localparam logic [1:0] OP_NONE   = 2'd3;

	// Register indexes (paddr bit 2)
	localparam logic REG_NODE_COUNT = 1'b0;
	localparam logic REG_REPLICA_K  = 1'b1;

	typedef struct packed {
		logic [1:0]        operation;
		logic [NODE_W-1:0] node_index;
		logic [KEY_W-1:0]  key;
	} req_t;

	typedef struct packed {
		logic [HOST_W-1:0] host_node;
		logic              host_valid;
		logic              last;
	} res_t;

	typedef enum logic [3:0] {
		ST_INIT,
		ST_IDLE,
		ST_WR_RD,
		ST_WR_UPD,
		ST_MOD,
		ST_COUNT,
		ST_HOME,
		ST_HOME_CHK,
		ST_LOOP,
		ST_SCAN_R,
		ST_SCAN_L,
		ST_DECIDE,
		ST_FIN_CHK,
		ST_FINISH
	} state_t;

	// Bitmap read address select
	typedef enum logic [2:0] {
		RSEL_IDX,
		RSEL_SWEEP,
		RSEL_HOME,
		RSEL_RIGHT,
		RSEL_RNEXT,
		RSEL_LEFT,
		RSEL_LNEXT
	} rsel_t;

	// Source of a taken host
	typedef enum logic [1:0] {
		TSRC_HOME,
		TSRC_RIGHT,
		TSRC_LEFT
	} tsrc_t;

	typedef struct packed {
		logic  load;
		logic  map_wr;
		logic  count_start;
		logic  count_step;
		logic  ptr_init;
		logic  r_adv;
		logic  l_adv;
		logic  take;
		logic  finish;
		rsel_t rsel;
		tsrc_t tsrc;
	} cmd_t;

	typedef struct packed {
		logic mod_busy;
		logic rbit;
		logic out_free;
		logic take_ok;
		logic loop_go;
		logic final_go;
		logic take_left;
		logic dirty;
		logic live_zero;
		logic count_done;
		logic clr_done;
	} sts_t;

endpackage

[src/rrhs_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module rrhs_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 1024,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

[src/rrhs_mod.sv]
// Iterative key modulo node count, one key bit per cycle.
module rrhs_mod #(
	parameter int NW = 11
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [rrhs_pkg::KEY_W-1:0]    dividend,
	input  logic [NW-1:0]                 divisor,
	output logic                          busy,
	output logic [NW-1:0]                 rem
);

	localparam int SW = $clog2(rrhs_pkg::KEY_W + 1);

	logic [SW-1:0]              steps_q;
	logic                       busy_q;
	logic [rrhs_pkg::KEY_W-1:0] shreg_q;
	logic [NW:0]                rem_q;
	logic [NW:0]                trial;

	// shift in the next key bit and subtract the divisor when it fits
	assign trial = {rem_q[NW-1:0], shreg_q[rrhs_pkg::KEY_W-1]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			steps_q <= '0;
		end else if (start) begin
			busy_q  <= 1'b1;
			steps_q <= SW'(rrhs_pkg::KEY_W);
		end else if (busy_q) begin
			steps_q <= steps_q - SW'(1);
			busy_q  <= (steps_q != SW'(1));
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			shreg_q <= dividend;
			rem_q   <= '0;
		end else if (busy_q) begin
			shreg_q <= {shreg_q[rrhs_pkg::KEY_W-2:0], 1'b0};
			if (trial >= {1'b0, divisor}) begin
				rem_q <= trial - {1'b0, divisor};
			end else begin
				rem_q <= trial;
			end
		end
	end

	assign busy = busy_q;
	assign rem  = rem_q[NW-1:0];

endmodule

[src/rrhs_dp.sv]
// Datapath: service bitmap, walk pointers, live count and result register.
module rrhs_dp #(
	parameter int NODES = rrhs_pkg::NODES_DEF,
	parameter int MAX_REPLICAS = rrhs_pkg::MAX_REPL_DEF,
	localparam int IW = $clog2(NODES),
	localparam int NW = $clog2(NODES + 1),
	localparam int CW = $clog2(MAX_REPLICAS + 1)
) (
	input  logic           clk,
	input  logic           arst_n,
	input  rrhs_pkg::cmd_t cmd,
	input  rrhs_pkg::req_t req,
	input  logic [NW-1:0]  n_eff,
	input  logic [CW-1:0]  k_eff,
	input  logic           n_wr,
	input  logic           res_stall,
	output logic           res_valid,
	output rrhs_pkg::res_t res,
	output rrhs_pkg::sts_t sts
);

	// ring step helpers
	function automatic logic [IW-1:0] ring_inc(input logic [IW-1:0] x, input logic [NW-1:0] n);
		ring_inc = (NW'(x) == n - NW'(1)) ? '0 : x + IW'(1);
	endfunction

	function automatic logic [IW-1:0] ring_dec(input logic [IW-1:0] x, input logic [NW-1:0] n);
		ring_dec = (x == '0) ? IW'(n - NW'(1)) : x - IW'(1);
	endfunction

	logic [1:0]                 op_q;
	logic [rrhs_pkg::NODE_W-1:0] idx_q;
	logic [IW-1:0]              l_q, r_q, pend_q;
	logic                       pend_v_q;
	logic [CW-1:0]              cnt_q;
	logic [NW-1:0]              live_q;
	logic                       dirty_q;
	logic [NW-1:0]              sweep_q;
	logic                       sweep_s1;
	logic [NW-1:0]              clr_q;
	logic                       res_valid_q;
	rrhs_pkg::res_t             res_q;

	logic [NW-1:0] rem;
	logic          mod_busy;
	logic [IW-1:0] h, r_inc, l_dec, dist_l, dist_r, idx_addr, sel_node, raddr, waddr;
	logic          rdata, we, wdata, clearing, idx_ok, idx_in_ring, new_bit, out_free;

	rrhs_mod #(.NW(NW)) u_mod (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.load),
		.dividend (req.key),
		.divisor  (n_eff),
		.busy     (mod_busy),
		.rem      (rem)
	);

	assign h        = IW'(rem);
	assign r_inc    = ring_inc(r_q, n_eff);
	assign l_dec    = ring_dec(l_q, n_eff);
	assign dist_l   = (l_q > h) ? (l_q - h) : (h - l_q);
	assign dist_r   = (r_q > h) ? (r_q - h) : (h - r_q);
	assign idx_addr = IW'(idx_q);
	assign idx_ok   = (32'(idx_q) < NODES);
	assign idx_in_ring = (32'(idx_q) < 32'(n_eff));
	assign new_bit  = (op_q == rrhs_pkg::OP_UP);
	assign clearing = (clr_q != NW'(NODES));
	assign out_free = !res_valid_q || !res_stall;

	// bitmap read address
	always_comb begin
		unique case (cmd.rsel)
			rrhs_pkg::RSEL_IDX:   raddr = idx_addr;
			rrhs_pkg::RSEL_SWEEP: raddr = sweep_q[IW-1:0];
			rrhs_pkg::RSEL_HOME:  raddr = h;
			rrhs_pkg::RSEL_RIGHT: raddr = r_q;
			rrhs_pkg::RSEL_RNEXT: raddr = r_inc;
			rrhs_pkg::RSEL_LEFT:  raddr = l_q;
			rrhs_pkg::RSEL_LNEXT: raddr = l_dec;
			default:              raddr = r_q;
		endcase
	end

	// taken host source
	always_comb begin
		unique case (cmd.tsrc)
			rrhs_pkg::TSRC_HOME:  sel_node = h;
			rrhs_pkg::TSRC_RIGHT: sel_node = r_q;
			rrhs_pkg::TSRC_LEFT:  sel_node = l_q;
			default:              sel_node = r_q;
		endcase
	end

	// bitmap write: clearing pass after reset, else service updates
	assign we    = clearing || (cmd.map_wr && idx_ok);
	assign waddr = clearing ? clr_q[IW-1:0] : idx_addr;
	assign wdata = clearing ? 1'b1 : new_bit;

	rrhs_ram #(.WIDTH(1), .DEPTH(NODES)) u_map (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q       <= '0;
			dirty_q     <= 1'b1;
			live_q      <= '0;
			sweep_s1    <= 1'b0;
			pend_v_q    <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (clearing) begin
				clr_q <= clr_q + NW'(1);
			end

			// live count: recount sweep or incremental update
			if (n_wr) begin
				dirty_q <= 1'b1;
			end else if (cmd.count_start) begin
				dirty_q <= 1'b0;
			end
			if (cmd.count_start) begin
				live_q   <= '0;
				sweep_s1 <= 1'b0;
			end else if (cmd.count_step) begin
				sweep_s1 <= (sweep_q != n_eff);
				if (sweep_s1 && rdata) begin
					live_q <= live_q + NW'(1);
				end
			end else if (cmd.map_wr && !dirty_q && idx_ok && idx_in_ring) begin
				if (new_bit && !rdata) begin
					live_q <= live_q + NW'(1);
				end else if (!new_bit && rdata) begin
					live_q <= live_q - NW'(1);
				end
			end

			if (cmd.load || cmd.finish) begin
				pend_v_q <= 1'b0;
			end else if (cmd.take) begin
				pend_v_q <= 1'b1;
			end

			if (cmd.finish || (cmd.take && pend_v_q)) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q  <= req.operation;
			idx_q <= req.node_index;
			cnt_q <= '0;
		end else if (cmd.take) begin
			cnt_q <= cnt_q + CW'(1);
		end

		if (cmd.count_start) begin
			sweep_q <= '0;
		end else if (cmd.count_step && (sweep_q != n_eff)) begin
			sweep_q <= sweep_q + NW'(1);
		end

		if (cmd.ptr_init) begin
			l_q <= ring_dec(h, n_eff);
			r_q <= ring_inc(h, n_eff);
		end else begin
			if (cmd.r_adv) begin
				r_q <= r_inc;
			end
			if (cmd.l_adv) begin
				l_q <= l_dec;
			end
		end

		// one host is held back so that the final one can carry last
		if (cmd.take) begin
			pend_q <= sel_node;
		end
		if (cmd.finish) begin
			res_q.host_node  <= pend_v_q ? rrhs_pkg::HOST_W'(pend_q) : '0;
			res_q.host_valid <= pend_v_q;
			res_q.last       <= 1'b1;
		end else if (cmd.take && pend_v_q) begin
			res_q.host_node  <= rrhs_pkg::HOST_W'(pend_q);
			res_q.host_valid <= 1'b1;
			res_q.last       <= 1'b0;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

	// status to the controller
	assign sts.mod_busy   = mod_busy;
	assign sts.rbit       = rdata;
	assign sts.out_free   = out_free;
	assign sts.take_ok    = !pend_v_q || out_free;
	assign sts.loop_go    = (cnt_q < k_eff) && (32'(cnt_q) < 32'(live_q)) && (l_q != r_q);
	assign sts.final_go   = (cnt_q < k_eff) && (l_q == r_q);
	assign sts.take_left  = (dist_l < dist_r);
	assign sts.dirty      = dirty_q;
	assign sts.live_zero  = (live_q == '0);
	assign sts.count_done = (sweep_q == n_eff) && !sweep_s1;
	assign sts.clr_done   = !clearing;

endmodule

[src/rrhs_ctrl.sv]
// Controller: sequences service updates and the two-pointer lookup walk.
module rrhs_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	input  logic [1:0]     req_op,
	input  rrhs_pkg::sts_t sts,
	output logic           req_stall,
	output rrhs_pkg::cmd_t cmd
);

	rrhs_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rrhs_pkg::ST_INIT;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		req_stall = 1'b1;
		unique case (state_q)
			rrhs_pkg::ST_INIT: begin
				if (sts.clr_done) begin
					state_d = rrhs_pkg::ST_IDLE;
				end
			end
			rrhs_pkg::ST_IDLE: begin
				req_stall = 1'b0;
				if (req_valid) begin
					cmd.load = 1'b1;
					unique case (req_op)
						rrhs_pkg::OP_UP, rrhs_pkg::OP_DOWN: state_d = rrhs_pkg::ST_WR_RD;
						rrhs_pkg::OP_LOOKUP:                state_d = rrhs_pkg::ST_MOD;
						default:                            state_d = rrhs_pkg::ST_IDLE;
					endcase
				end
			end
			// read the old bit, then write the new one
			rrhs_pkg::ST_WR_RD: begin
				cmd.rsel = rrhs_pkg::RSEL_IDX;
				state_d  = rrhs_pkg::ST_WR_UPD;
			end
			rrhs_pkg::ST_WR_UPD: begin
				cmd.map_wr = 1'b1;
				state_d    = rrhs_pkg::ST_IDLE;
			end
			rrhs_pkg::ST_MOD: begin
				if (!sts.mod_busy) begin
					if (sts.dirty) begin
						cmd.count_start = 1'b1;
						state_d         = rrhs_pkg::ST_COUNT;
					end else begin
						state_d = rrhs_pkg::ST_HOME;
					end
				end
			end
			rrhs_pkg::ST_COUNT: begin
				cmd.count_step = 1'b1;
				cmd.rsel       = rrhs_pkg::RSEL_SWEEP;
				if (sts.count_done) begin
					state_d = rrhs_pkg::ST_HOME;
				end
			end
			rrhs_pkg::ST_HOME: begin
				if (sts.live_zero) begin
					state_d = rrhs_pkg::ST_FINISH;
				end else begin
					cmd.ptr_init = 1'b1;
					cmd.rsel     = rrhs_pkg::RSEL_HOME;
					state_d      = rrhs_pkg::ST_HOME_CHK;
				end
			end
			rrhs_pkg::ST_HOME_CHK: begin
				cmd.rsel = rrhs_pkg::RSEL_HOME;
				cmd.tsrc = rrhs_pkg::TSRC_HOME;
				if (!sts.rbit) begin
					state_d = rrhs_pkg::ST_LOOP;
				end else if (sts.take_ok) begin
					cmd.take = 1'b1;
					state_d  = rrhs_pkg::ST_LOOP;
				end
			end
			rrhs_pkg::ST_LOOP: begin
				cmd.rsel = rrhs_pkg::RSEL_RIGHT;
				priority if (sts.loop_go) begin
					state_d = rrhs_pkg::ST_SCAN_R;
				end else if (sts.final_go) begin
					state_d = rrhs_pkg::ST_FIN_CHK;
				end else begin
					state_d = rrhs_pkg::ST_FINISH;
				end
			end
			// skip out-of-service nodes, one probe per cycle
			rrhs_pkg::ST_SCAN_R: begin
				if (sts.rbit) begin
					cmd.rsel = rrhs_pkg::RSEL_LEFT;
					state_d  = rrhs_pkg::ST_SCAN_L;
				end else begin
					cmd.r_adv = 1'b1;
					cmd.rsel  = rrhs_pkg::RSEL_RNEXT;
				end
			end
			rrhs_pkg::ST_SCAN_L: begin
				if (sts.rbit) begin
					state_d = rrhs_pkg::ST_DECIDE;
				end else begin
					cmd.l_adv = 1'b1;
					cmd.rsel  = rrhs_pkg::RSEL_LNEXT;
				end
			end
			// nearer side wins, tie goes right
			rrhs_pkg::ST_DECIDE: begin
				if (sts.take_ok) begin
					cmd.take = 1'b1;
					state_d  = rrhs_pkg::ST_LOOP;
					if (sts.take_left) begin
						cmd.tsrc  = rrhs_pkg::TSRC_LEFT;
						cmd.l_adv = 1'b1;
					end else begin
						cmd.tsrc  = rrhs_pkg::TSRC_RIGHT;
						cmd.r_adv = 1'b1;
					end
				end
			end
			// pointers met: take the meeting node if in service
			rrhs_pkg::ST_FIN_CHK: begin
				cmd.rsel = rrhs_pkg::RSEL_RIGHT;
				cmd.tsrc = rrhs_pkg::TSRC_RIGHT;
				if (!sts.rbit) begin
					state_d = rrhs_pkg::ST_FINISH;
				end else if (sts.take_ok) begin
					cmd.take = 1'b1;
					state_d  = rrhs_pkg::ST_FINISH;
				end
			end
			rrhs_pkg::ST_FINISH: begin
				if (sts.out_free) begin
					cmd.finish = 1'b1;
					state_d    = rrhs_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = rrhs_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

[src/ring_replica_host_selector_core.sv]
// Ring replica host selector: service bitmap in a RAM, lookups walked by a sequencer.
// Sequence: an update reads the old bit, then writes the new one. A lookup takes key mod
//   node_count, recounts live nodes after reset or a node_count write, checks the home
//   node and the loop, takes further hosts past out-of-service nodes, and closes.
// Throughput: one item at a time; the next follows the last write or closing result.
// Reset: a clearing pass marks every node in service while req_stall stays high.
module ring_replica_host_selector_core #(
	parameter int NODES = rrhs_pkg::NODES_DEF,
	parameter int MAX_REPLICAS = rrhs_pkg::MAX_REPL_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [rrhs_pkg::APB_AW-1:0] paddr,
	input  logic [rrhs_pkg::APB_DW-1:0] pwdata,
	output logic [rrhs_pkg::APB_DW-1:0] prdata,
	output logic                        pready,
	input  logic                        req_valid,
	output logic                        req_stall,
	input  rrhs_pkg::req_t              req_data,
	output logic                        res_valid,
	input  logic                        res_stall,
	output rrhs_pkg::res_t              res_data
);

	localparam int NW = $clog2(NODES + 1);
	localparam int CW = $clog2(MAX_REPLICAS + 1);

	logic [rrhs_pkg::CFG_N_W-1:0] node_count_q;
	logic [rrhs_pkg::CFG_K_W-1:0] replica_k_q;
	logic                         cfg_wr, n_wr;
	logic [31:0]                  n_raw, k_raw;
	logic [NW-1:0]                n_eff;
	logic [CW-1:0]                k_eff;
	rrhs_pkg::cmd_t               cmd;
	rrhs_pkg::sts_t               sts;

	// configuration registers
	assign cfg_wr = psel && penable && pwrite;
	assign n_wr   = cfg_wr && (paddr[2] == rrhs_pkg::REG_NODE_COUNT);
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_count_q <= rrhs_pkg::CFG_N_RST;
			replica_k_q  <= rrhs_pkg::CFG_K_RST;
		end else if (cfg_wr) begin
			if (paddr[2] == rrhs_pkg::REG_NODE_COUNT) begin
				node_count_q <= pwdata[rrhs_pkg::CFG_N_W-1:0];
			end else begin
				replica_k_q <= pwdata[rrhs_pkg::CFG_K_W-1:0];
			end
		end
	end

	assign prdata = (paddr[2] == rrhs_pkg::REG_REPLICA_K) ? 32'(replica_k_q) : 32'(node_count_q);

	// saturate register values to the working range
	assign n_raw = 32'(node_count_q);
	assign k_raw = 32'(replica_k_q);
	assign n_eff = (n_raw < 32'd2) ? NW'(2) : ((n_raw > NODES) ? NW'(NODES) : NW'(n_raw));
	assign k_eff = (k_raw < 32'd1) ? CW'(1) :
	               ((k_raw > MAX_REPLICAS) ? CW'(MAX_REPLICAS) : CW'(k_raw));

	rrhs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_op    (req_data.operation),
		.sts       (sts),
		.req_stall (req_stall),
		.cmd       (cmd)
	);

	rrhs_dp #(
		.NODES        (NODES),
		.MAX_REPLICAS (MAX_REPLICAS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.req       (req_data),
		.n_eff     (n_eff),
		.k_eff     (k_eff),
		.n_wr      (n_wr),
		.res_stall (res_stall),
		.res_valid (res_valid),
		.res       (res_data),
		.sts       (sts)
	);

	// a no-host result always closes its request
	a_nohost_last: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_data.host_valid |-> res_data.last)
		else $error("no-host result without last");

	// a selected host lies on the ring in use
	a_host_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_data.host_valid |-> (32'(res_data.host_node) < 32'(n_eff)))
		else $error("host outside ring");

	// the closing result never overwrites one still waiting
	a_finish_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |-> sts.out_free)
		else $error("final result overwrote pending output");

	// a take that pushes out a held host needs a free output slot
	a_take_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.take |-> sts.take_ok)
		else $error("host taken with output slot busy");

endmodule

[verif/ring_replica_host_selector_core_tb.sv]
// Self-checking testbench for the ring replica host selector core.
module ring_replica_host_selector_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned LIMIT_CYCLES  = 2_000_000;
	localparam int unsigned SETTLE_CYCLES = 40;
	localparam int unsigned HOLD_CYCLES   = 400;

	logic                          clk;
	logic                          arst_n;
	logic                          psel;
	logic                          penable;
	logic                          pwrite;
	logic [rrhs_pkg::APB_AW-1:0]   paddr;
	logic [rrhs_pkg::APB_DW-1:0]   pwdata;
	logic [rrhs_pkg::APB_DW-1:0]   prdata;
	logic                          pready;
	logic                          req_valid;
	logic                          req_stall;
	rrhs_pkg::req_t                req_data;
	logic                          res_valid;
	logic                          res_stall;
	rrhs_pkg::res_t                res_data;

	// Local copy of the block state and registers
	logic [rrhs_pkg::NODES_DEF-1:0] svc_map;
	logic [rrhs_pkg::CFG_N_W-1:0]   node_cnt_reg;
	logic [rrhs_pkg::CFG_K_W-1:0]   repl_k_reg;

	rrhs_pkg::res_t expected_hosts[$];
	int unsigned    chosen_hosts[$];
	rrhs_pkg::res_t want;

	int unsigned errs;
	int unsigned n_requests;
	int unsigned n_lookups;
	int unsigned n_results;
	int unsigned n_writes;
	int unsigned cycle_count;

	// Receiver idling control
	bit          calm;
	int unsigned hold_asked;
	int unsigned hold_seen;
	int unsigned hold_left;
	int unsigned stall_left;

	ring_replica_host_selector_core u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req_data  (req_data),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res_data  (res_data)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Effective ring size and host limit after saturation
	function automatic int unsigned ring_size();
		int unsigned n;
		n = 32'(node_cnt_reg);
		if (n < 2) n = 2;
		if (n > rrhs_pkg::NODES_DEF) n = rrhs_pkg::NODES_DEF;
		return n;
	endfunction

	function automatic int unsigned host_limit();
		int unsigned k;
		k = 32'(repl_k_reg);
		if (k < 1) k = 1;
		if (k > rrhs_pkg::MAX_REPL_DEF) k = rrhs_pkg::MAX_REPL_DEF;
		return k;
	endfunction

	function automatic int unsigned ring_gap(int unsigned a, int unsigned b);
		return (a > b) ? a - b : b - a;
	endfunction

	// Add a host to the current selection unless already chosen or the list is full
	function automatic void pick_host(int unsigned node);
		foreach (chosen_hosts[i])
			if (chosen_hosts[i] == node) return;
		if (chosen_hosts.size() < rrhs_pkg::MAX_REPL_DEF) chosen_hosts = {chosen_hosts, node};
	endfunction

	// Walk the ring from the home node and queue the hosts the block must return
	function automatic void predict_hosts(logic [rrhs_pkg::KEY_W-1:0] key);
		int unsigned n, k, live, h, l, r;
		rrhs_pkg::res_t item;
		n = ring_size();
		k = host_limit();
		live = 0;
		chosen_hosts.delete();
		for (int unsigned i = 0; i < n; i++)
			if (svc_map[i]) live++;
		if (live != 0) begin
			h = key % n;
			l = (h + n - 1) % n;
			r = (h + 1) % n;
			if (svc_map[h]) pick_host(h);
			while (chosen_hosts.size() < k && chosen_hosts.size() < live && l != r) begin
				while (!svc_map[r]) r = (r + 1) % n;
				while (!svc_map[l]) l = (l + n - 1) % n;
				if (ring_gap(l, h) < ring_gap(r, h)) begin
					pick_host(l);
					l = (l + n - 1) % n;
				end else begin
					pick_host(r);
					r = (r + 1) % n;
				end
			end
			if (chosen_hosts.size() < k && l == r && svc_map[r]) pick_host(r);
		end
		// no host in service: a single empty result
		if (chosen_hosts.size() == 0) begin
			item.host_node  = '0;
			item.host_valid = 1'b0;
			item.last       = 1'b1;
			expected_hosts = {expected_hosts, item};
		end else begin
			foreach (chosen_hosts[i]) begin
				item.host_node  = chosen_hosts[i][rrhs_pkg::HOST_W-1:0];
				item.host_valid = 1'b1;
				item.last       = (i == chosen_hosts.size() - 1);
				expected_hosts = {expected_hosts, item};
			end
		end
	endfunction

	// Apply one accepted request to the local state
	function automatic void apply_to_ring(rrhs_pkg::req_t it);
		case (it.operation)
			rrhs_pkg::OP_UP:     svc_map[it.node_index] = 1'b1;
			rrhs_pkg::OP_DOWN:   svc_map[it.node_index] = 1'b0;
			rrhs_pkg::OP_LOOKUP: begin
				n_lookups++;
				predict_hosts(it.key);
			end
			default: ;
		endcase
	endfunction

	function automatic rrhs_pkg::req_t random_request(int unsigned n, int unsigned down_pct);
		rrhs_pkg::req_t it;
		int unsigned roll;
		roll = $urandom_range(0, 99);
		it.key = $urandom();
		if ($urandom_range(0, 4) == 0)
			it.node_index = rrhs_pkg::NODE_W'($urandom_range(0, rrhs_pkg::NODES_DEF - 1));
		else
			it.node_index = rrhs_pkg::NODE_W'($urandom_range(0, n - 1));
		if (roll < down_pct)
			it.operation = rrhs_pkg::OP_DOWN;
		else if (roll < down_pct + 25)
			it.operation = rrhs_pkg::OP_UP;
		else if (roll < 95)
			it.operation = rrhs_pkg::OP_LOOKUP;
		else
			it.operation = rrhs_pkg::OP_NONE;
		return it;
	endfunction

	function automatic rrhs_pkg::req_t make_request(logic [1:0] op,
			logic [rrhs_pkg::NODE_W-1:0] idx, logic [rrhs_pkg::KEY_W-1:0] key);
		rrhs_pkg::req_t it;
		it.operation  = op;
		it.node_index = idx;
		it.key        = key;
		return it;
	endfunction

	// Offer one request and hold it until accepted, then maybe idle
	task automatic send_request(rrhs_pkg::req_t it, bit allow_gap);
		req_valid <= 1'b1;
		req_data  <= it;
		do @(posedge clk); while (req_stall);
		n_requests++;
		apply_to_ring(it);
		if (allow_gap && $urandom_range(0, 3) == 0) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 11)) @(posedge clk);
		end
	endtask

	// Register write: setup cycle, access cycle, then bus idle
	task automatic write_reg(logic idx, logic [rrhs_pkg::APB_DW-1:0] val);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= val;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		if (idx == rrhs_pkg::REG_NODE_COUNT)
			node_cnt_reg = val[rrhs_pkg::CFG_N_W-1:0];
		else
			repl_k_reg = val[rrhs_pkg::CFG_K_W-1:0];
		n_writes++;
		@(posedge clk);
	endtask

	// Drain all expected hosts, then let the last update finish
	task automatic wait_for_idle();
		req_valid <= 1'b0;
		while (expected_hosts.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic test_reset_defaults();
		send_request(make_request(rrhs_pkg::OP_LOOKUP, 10'd0, 32'd0), 1'b1);
		send_request(make_request(rrhs_pkg::OP_LOOKUP, 10'd0, 32'hFFFF_FFFF), 1'b1);
		send_request(make_request(rrhs_pkg::OP_LOOKUP, 10'h3FF, 32'd512), 1'b1);
		// unused code is ignored whatever the other fields hold
		send_request(make_request(rrhs_pkg::OP_NONE, 10'h3FF, 32'hFFFF_FFFF), 1'b1);
	endtask

	task automatic test_register_limits();
		wait_for_idle();
		// oversized values saturate to the ring size and the host limit
		write_reg(rrhs_pkg::REG_NODE_COUNT, 32'd2047);
		write_reg(rrhs_pkg::REG_REPLICA_K, 32'd31);
		send_request(make_request(rrhs_pkg::OP_LOOKUP, 10'd0, $urandom()), 1'b1);
		wait_for_idle();
		// zero and one act as the smallest ring and a single host
		write_reg(rrhs_pkg::REG_NODE_COUNT, 32'd0);
		write_reg(rrhs_pkg::REG_REPLICA_K, 32'd0);
		send_request(make_request(rrhs_pkg::OP_LOOKUP, 10'd0, 32'd1), 1'b1);
		wait_for_idle();
		write_reg(rrhs_pkg::REG_NODE_COUNT, 32'd1);
		write_reg(rrhs_pkg::REG_REPLICA_K, 32'd16);
		send_request(make_request(rrhs_pkg::OP_LOOKUP, 10'd0, 32'd0), 1'b1);
	endtask

	task automatic test_all_out_of_service();
		wait_for_idle();
		write_reg(rrhs_pkg::REG_NODE_COUNT, 32'd4);
		write_reg(rrhs_pkg::REG_REPLICA_K, 32'd3);
		for (int unsigned i = 0; i < 4; i++)
			send_request(make_request(rrhs_pkg::OP_DOWN, i[rrhs_pkg::NODE_W-1:0], $urandom()),
				1'b1);
		send_request(make_request(rrhs_pkg::OP_LOOKUP, 10'd0, 32'd5), 1'b1);
		// a single live node, fewer than the host limit
		send_request(make_request(rrhs_pkg::OP_UP, 10'd2, $urandom()), 1'b1);
		send_request(make_request(rrhs_pkg::OP_LOOKUP, 10'd0, 32'd0), 1'b1);
	endtask

	task automatic test_outside_ring();
		wait_for_idle();
		write_reg(rrhs_pkg::REG_NODE_COUNT, 32'd8);
		write_reg(rrhs_pkg::REG_REPLICA_K, 32'd4);
		// node beyond the ring keeps its bit without affecting lookups
		send_request(make_request(rrhs_pkg::OP_DOWN, 10'd1000, $urandom()), 1'b1);
		send_request(make_request(rrhs_pkg::OP_LOOKUP, 10'd0, 32'd3), 1'b1);
		wait_for_idle();
		write_reg(rrhs_pkg::REG_NODE_COUNT, 32'd1024);
		send_request(make_request(rrhs_pkg::OP_LOOKUP, 10'd0, 32'd1000), 1'b1);
		send_request(make_request(rrhs_pkg::OP_UP, 10'd1000, $urandom()), 1'b1);
		send_request(make_request(rrhs_pkg::OP_LOOKUP, 10'd0, 32'd1000), 1'b1);
	endtask

	// Receiver holds off while lookups keep coming back to back
	task automatic test_backpressure();
		wait_for_idle();
		write_reg(rrhs_pkg::REG_NODE_COUNT, 32'd16);
		write_reg(rrhs_pkg::REG_REPLICA_K, 32'd16);
		hold_asked++;
		repeat (8) send_request(make_request(rrhs_pkg::OP_LOOKUP,
			rrhs_pkg::NODE_W'($urandom_range(0, 1023)), $urandom()), 1'b0);
	endtask

	task automatic test_random_churn();
		logic [rrhs_pkg::APB_DW-1:0] nval;
		logic [rrhs_pkg::APB_DW-1:0] kval;
		int unsigned down_pct;
		for (int unsigned ph = 0; ph < 6; ph++) begin
			case (ph)
				0: begin
					nval = 32'd2;
					kval = 32'd16;
				end
				1: begin
					nval = 32'd1024;
					kval = 32'd1;
				end
				2: begin
					// junk above the register width is dropped
					nval = ($urandom() << rrhs_pkg::CFG_N_W) | $urandom_range(3, 64);
					kval = ($urandom() << rrhs_pkg::CFG_K_W) | $urandom_range(0, 31);
				end
				default: begin
					nval = $urandom_range(3, 64);
					kval = $urandom_range(0, 31);
				end
			endcase
			wait_for_idle();
			write_reg(rrhs_pkg::REG_NODE_COUNT, nval);
			write_reg(rrhs_pkg::REG_REPLICA_K, kval);
			down_pct = $urandom_range(10, 50);
			repeat (30) send_request(random_request(ring_size(), down_pct), 1'b1);
		end
	endtask

	// Final stretch with no idling on either side
	task automatic test_steady_tail();
		wait_for_idle();
		write_reg(rrhs_pkg::REG_NODE_COUNT, 32'd12);
		write_reg(rrhs_pkg::REG_REPLICA_K, 32'd5);
		calm = 1'b1;
		repeat (20) send_request(random_request(ring_size(), 30), 1'b0);
	endtask

	// Result stall: long hold when asked, else random bursts
	initial begin
		res_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_seen != hold_asked) begin
				hold_seen = hold_asked;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left != 0) begin
				hold_left--;
				res_stall <= 1'b1;
			end else if (stall_left != 0) begin
				stall_left--;
				res_stall <= 1'b1;
			end else if (!calm && $urandom_range(0, 7) == 0) begin
				stall_left = $urandom_range(0, 10);
				res_stall <= 1'b1;
			end else begin
				res_stall <= 1'b0;
			end
		end
	end

	// Compare each accepted result with the oldest expected host
	always @(posedge clk) begin
		if (arst_n && res_valid && !res_stall) begin
			n_results++;
			if (expected_hosts.size() == 0) begin
				$error("unexpected result host_node=%0d host_valid=%0b last=%0b",
					res_data.host_node, res_data.host_valid, res_data.last);
				errs++;
			end else begin
				want = expected_hosts.pop_front();
				if (res_data.host_node !== want.host_node) begin
					$error("host_node expected %0d actual %0d", want.host_node,
						res_data.host_node);
					errs++;
				end
				if (res_data.host_valid !== want.host_valid) begin
					$error("host_valid expected %0b actual %0b", want.host_valid,
						res_data.host_valid);
					errs++;
				end
				if (res_data.last !== want.last) begin
					$error("last expected %0b actual %0b", want.last, res_data.last);
					errs++;
				end
			end
		end
	end

	// Timeout
	initial begin
		cycle_count = 0;
		while (cycle_count < LIMIT_CYCLES) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("timeout after %0d cycles", cycle_count);
		$display("status: fail");
		$finish;
	end

	initial begin
		arst_n     <= 1'b0;
		psel       <= 1'b0;
		penable    <= 1'b0;
		pwrite     <= 1'b0;
		paddr      <= '0;
		pwdata     <= '0;
		req_valid  <= 1'b0;
		req_data   <= '0;
		svc_map      = '1;
		node_cnt_reg = rrhs_pkg::CFG_N_RST;
		repl_k_reg   = rrhs_pkg::CFG_K_RST;
		calm       = 1'b0;
		hold_asked = 0;
		hold_seen  = 0;
		hold_left  = 0;
		stall_left = 0;
		errs       = 0;
		n_requests = 0;
		n_lookups  = 0;
		n_results  = 0;
		n_writes   = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_defaults();
		test_register_limits();
		test_all_out_of_service();
		test_outside_ring();
		test_backpressure();
		test_random_churn();
		test_steady_tail();
		wait_for_idle();

		$display("covered %0d requests (%0d lookups) and %0d register writes",
			n_requests, n_lookups, n_writes);
		$display("checked %0d host results over ring sizes 2 to 1024, %0d mismatches",
			n_results, errs);
		if (errs == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

[files.f]
src/rrhs_pkg.sv
src/rrhs_ram.sv
src/rrhs_mod.sv
src/rrhs_dp.sv
src/rrhs_ctrl.sv
src/ring_replica_host_selector_core.sv
verif/ring_replica_host_selector_core_tb.sv
